[src/lsf_pkg.sv]
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared constants, types and helpers of the least-squares line fit core.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int SQ_W        = 2 * SAMPLE_BITS + CNT_W - 1;

  // iterative arithmetic unit
  localparam int OPW    = 64;
  localparam int PW     = 2 * OPW;
  localparam int NUMW   = 80;
  localparam int AW     = 68;
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(OPW);
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(NUMW);
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(PW / 2);

  localparam int WIDE_W = 80;
  localparam int RES_W  = 64;
  localparam int OUT_W  = 32;
  localparam int CORR_W = 17;
  localparam int MG_W   = 16;
  localparam int ERR_W  = 57;
  localparam logic [ERR_W-1:0] ERR_CAP   = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic [MG_W-1:0]  CORR_CAP  = MG_W'(32768);
  localparam logic [6:0]       PCT_SCALE = 7'd100;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_X_FLAT   = 3'd1,
    STAT_Y_FLAT   = 3'd2,
    STAT_ZERO_Y   = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACC,
    ST_NSXY,
    ST_SXSY,
    ST_NSXX,
    ST_SXSX,
    ST_NSYY,
    ST_SYSY,
    ST_SXXSY,
    ST_SXSXY,
    ST_CHECK,
    ST_SLOPE,
    ST_ICPT,
    ST_DXDY,
    ST_SQRT,
    ST_CORR,
    ST_DET,
    ST_RD,
    ST_PX,
    ST_PDIV,
    ST_M100,
    ST_MDIV,
    ST_DONE
  } state_t;

  function automatic logic [WIDE_W-1:0] abs_wide(input logic signed [WIDE_W-1:0] v);
    abs_wide = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
  endfunction

  // clamp a quotient magnitude with sign to a signed 32-bit word
  function automatic logic [OUT_W-1:0] sat32(input logic [NUMW-1:0] q, input logic neg);
    logic [NUMW-1:0] neg_q;
    neg_q = -q;
    if (neg) begin
      sat32 = (q > NUMW'(33'h0_8000_0000)) ? 32'h8000_0000 : neg_q[OUT_W-1:0];
    end else begin
      sat32 = (q > NUMW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[OUT_W-1:0];
    end
  endfunction

endpackage

[src/lsf_mdu.sv]
// ----------------------------------------------------------------------------
// lsf_mdu
// Bit-serial multiply, divide and square root on one shared adder.
// ----------------------------------------------------------------------------
module lsf_mdu (
  input  logic                    clk,
  input  logic                    rst,
  input  lsf_pkg::mdu_req_t       req,
  input  logic [lsf_pkg::PW-1:0]  opnd_a,
  input  logic [lsf_pkg::OPW-1:0] opnd_b,
  output logic                    done,
  output logic [lsf_pkg::PW-1:0]  result
);
  import lsf_pkg::*;

  logic              busy;
  mdu_op_t           op_r;
  logic [STEP_W-1:0] cnt;
  logic [PW-1:0]     acc;
  logic [AW-1:0]     rem;
  logic [OPW-1:0]    root;
  logic [OPW-1:0]    bval;
  logic [AW-1:0]     add_a;
  logic [AW-1:0]     add_b;
  logic              add_sub;
  logic [AW:0]       add_sum;
  logic              ge;
  logic              launch;

  assign launch = req.start && !busy;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (op_r)
      OP_MUL: begin
        add_a = AW'(acc[PW-1:OPW]);
        add_b = acc[0] ? AW'(bval) : '0;
      end
      OP_DIV: begin
        add_a   = {rem[AW-2:0], acc[NUMW-1]};
        add_b   = AW'(bval);
        add_sub = 1'b1;
      end
      OP_SQRT: begin
        add_a   = {rem[AW-3:0], acc[PW-1 -: 2]};
        add_b   = AW'({root, 2'b01});
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {AW{add_sub}}} + (AW+1)'(add_sub);
  assign ge      = add_sum[AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (launch) begin
        busy <= 1'b1;
        op_r <= req.op;
        unique case (req.op)
          OP_MUL:  cnt <= MUL_STEPS;
          OP_DIV:  cnt <= DIV_STEPS;
          OP_SQRT: cnt <= SQRT_STEPS;
          default: cnt <= MUL_STEPS;
        endcase
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      bval <= opnd_b;
      rem  <= '0;
      root <= '0;
      case (req.op)
        OP_MUL:  acc <= {{OPW{1'b0}}, opnd_a[OPW-1:0]};
        OP_DIV:  acc <= {{(PW-NUMW){1'b0}}, opnd_a[NUMW-1:0]};
        default: acc <= opnd_a;
      endcase
    end else if (busy) begin
      case (op_r)
        OP_MUL: acc <= {add_sum[OPW:0], acc[OPW-1:1]};
        OP_DIV: begin
          rem <= ge ? add_sum[AW-1:0] : add_a;
          acc <= {acc[PW-2:0], ge};
        end
        OP_SQRT: begin
          rem  <= ge ? add_sum[AW-1:0] : add_a;
          root <= {root[OPW-2:0], ge};
          acc  <= {acc[PW-3:0], 2'b00};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (op_r)
      OP_MUL:  result = acc;
      OP_DIV:  result = {{(PW-NUMW){1'b0}}, acc[NUMW-1:0]};
      OP_SQRT: result = {{(PW-OPW){1'b0}}, root};
      default: result = acc;
    endcase
  end

endmodule

[src/lsf_store.sv]
// ----------------------------------------------------------------------------
// lsf_store
// Point memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lsf_store (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [lsf_pkg::ADDR_W-1:0]             wr_addr,
  input  logic signed [lsf_pkg::SAMPLE_BITS-1:0] wr_x,
  input  logic signed [lsf_pkg::SAMPLE_BITS-1:0] wr_y,
  input  logic                                   rd_en,
  input  logic [lsf_pkg::ADDR_W-1:0]             rd_addr,
  output logic signed [lsf_pkg::SAMPLE_BITS-1:0] rd_x,
  output logic signed [lsf_pkg::SAMPLE_BITS-1:0] rd_y
);
  import lsf_pkg::*;

  logic [2*SAMPLE_BITS-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
    if (rd_en) begin
      {rd_x, rd_y} <= mem[rd_addr];
    end
  end

endmodule

[src/linear_least_squares_fit_core.sv]
// ----------------------------------------------------------------------------
// linear_least_squares_fit_core
// Straight-line least-squares fit with correlation and percentage error.
// ----------------------------------------------------------------------------
//  channel | signals                                   | transfer
//  --------+-------------------------------------------+---------------------
//  in      | x_value, y_value, last_point              | in_valid & in_ready
//  out     | slope, intercept, correlation,            | out_valid & out_ready
//          | determination, mean_pct_error,            |
//          | point_count, status                       |
//
//  A stored point takes the transfer and three passes through the
//  16x16 multiplier for xy, xx and yy; a dropped point takes only the transfer.
//  The fit runs on the 64-step multiply / 80-step divide / 64-step root unit,
//  followed by an error pass over the stored points.
//  Reset clears the sums, the count and the flags; the point memory is not
//  cleared. A stalled result holds in the output register while new points
//  are taken; a second fit waits for it before it is loaded.
// ----------------------------------------------------------------------------
module linear_least_squares_fit_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [lsf_pkg::SAMPLE_BITS-1:0] x_value,
  input  logic signed [lsf_pkg::SAMPLE_BITS-1:0] y_value,
  input  logic                                   last_point,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lsf_pkg::OUT_W-1:0]       slope,
  output logic signed [lsf_pkg::OUT_W-1:0]       intercept,
  output logic signed [lsf_pkg::CORR_W-1:0]      correlation,
  output logic [lsf_pkg::CORR_W-1:0]             determination,
  output logic [lsf_pkg::OUT_W-1:0]              mean_pct_error,
  output logic [lsf_pkg::CNT_W-1:0]              point_count,
  output logic [2:0]                             status
);
  import lsf_pkg::*;

  state_t state, state_next;

  // accumulation
  logic [CNT_W-1:0]              count;
  logic signed [SUM_W-1:0]       acc_x, acc_y;
  logic signed [SQ_W-1:0]        acc_xy, acc_xx, acc_yy;
  logic                          dropped, zero_y;
  logic signed [SAMPLE_BITS-1:0] x_r, y_r;
  logic                          last_r;
  logic [1:0]                    phase;
  logic signed [SAMPLE_BITS-1:0] ma, mb;
  logic signed [2*SAMPLE_BITS-1:0] mprod;
  logic                          in_xfer, room;

  // fit
  logic signed [WIDE_W-1:0] p1, num, dx, dy, inum, prod_s;
  logic [PW-1:0]            rad;
  logic [OPW-1:0]           sroot;
  logic [MG_W-1:0]          mg, mg_new;
  logic signed [OUT_W-1:0]  slope_r, icpt_r;
  logic signed [CORR_W-1:0] corr_r;
  logic [CORR_W-1:0]        det_r;
  logic [OUT_W-1:0]         mape_r;
  status_t                  stat_r;
  logic [ADDR_W-1:0]        idx;
  logic [OPW-1:0]           resid;
  logic [ERR_W-1:0]         err_sum;
  logic [ERR_W:0]           err_add;
  logic [ERR_W-1:0]         term;
  logic signed [RES_W-1:0]  res64;
  logic                     dx_pos, dy_pos, last_idx, out_free;
  logic [NUMW-1:0]          quot;

  // shared unit
  mdu_req_t       mdu_req;
  logic [PW-1:0]  opa;
  logic [OPW-1:0] opb;
  logic           op_neg, use_mdu, issued, mdu_done;
  logic [PW-1:0]  mdu_res;

  logic                          rd_en;
  logic signed [SAMPLE_BITS-1:0] rd_x, rd_y;

  lsf_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .req    (mdu_req),
    .opnd_a (opa),
    .opnd_b (opb),
    .done   (mdu_done),
    .result (mdu_res)
  );

  lsf_store u_store (
    .clk     (clk),
    .wr_en   (in_xfer && room),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_x    (x_value),
    .wr_y    (y_value),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  assign in_xfer  = in_valid && in_ready;
  assign room     = count < CNT_W'(MAX_POINTS);
  assign dx_pos   = !dx[WIDE_W-1] && (dx != '0);
  assign dy_pos   = !dy[WIDE_W-1] && (dy != '0);
  assign last_idx = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign out_free = !out_valid || out_ready;

  // small multiplier for the sums of products
  always_comb begin
    case (phase)
      2'd1:    begin ma = x_r; mb = x_r; end
      2'd2:    begin ma = y_r; mb = y_r; end
      default: begin ma = x_r; mb = y_r; end
    endcase
  end
  assign mprod = ma * mb;

  assign quot    = mdu_res[NUMW-1:0];
  assign prod_s  = op_neg ? -WIDE_W'(mdu_res) : WIDE_W'(mdu_res);
  assign mg_new  = (quot > NUMW'(CORR_CAP)) ? CORR_CAP : quot[MG_W-1:0];
  assign res64   = (RES_W'(rd_y) <<< 16) - RES_W'(prod_s) - (RES_W'(icpt_r) <<< 8);
  assign term    = (quot > NUMW'(ERR_CAP)) ? ERR_CAP : quot[ERR_W-1:0];
  assign err_add = {1'b0, err_sum} + {1'b0, term};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (room) state_next = ST_ACC;
          else if (last_point) state_next = ST_NSXY;
        end
      end
      ST_ACC:   if (phase == 2'd2) state_next = last_r ? ST_NSXY : ST_IDLE;
      ST_NSXY:  if (mdu_done) state_next = ST_SXSY;
      ST_SXSY:  if (mdu_done) state_next = ST_NSXX;
      ST_NSXX:  if (mdu_done) state_next = ST_SXSX;
      ST_SXSX:  if (mdu_done) state_next = ST_NSYY;
      ST_NSYY:  if (mdu_done) state_next = ST_SYSY;
      ST_SYSY:  if (mdu_done) state_next = ST_SXXSY;
      ST_SXXSY: if (mdu_done) state_next = ST_SXSXY;
      ST_SXSXY: if (mdu_done) state_next = ST_CHECK;
      ST_CHECK: state_next = dx_pos ? ST_SLOPE : ST_DONE;
      ST_SLOPE: if (mdu_done) state_next = ST_ICPT;
      ST_ICPT: begin
        if (mdu_done) begin
          if (dy_pos) state_next = ST_DXDY;
          else state_next = zero_y ? ST_DONE : ST_RD;
        end
      end
      ST_DXDY:  if (mdu_done) state_next = ST_SQRT;
      ST_SQRT:  if (mdu_done) state_next = ST_CORR;
      ST_CORR:  if (mdu_done) state_next = ST_DET;
      ST_DET:   if (mdu_done) state_next = zero_y ? ST_DONE : ST_RD;
      ST_RD:    state_next = ST_PX;
      ST_PX:    if (mdu_done) state_next = ST_PDIV;
      ST_PDIV:  if (mdu_done) state_next = last_idx ? ST_M100 : ST_RD;
      ST_M100:  if (mdu_done) state_next = ST_MDIV;
      ST_MDIV:  if (mdu_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: operand selection and strobes
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    use_mdu  = 1'b1;
    op_neg   = 1'b0;
    mdu_req  = '{start: 1'b0, op: OP_MUL};
    opa      = '0;
    opb      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        use_mdu  = 1'b0;
      end
      ST_NSXY: begin
        opa    = PW'(count);
        opb    = OPW'(abs_wide(WIDE_W'(acc_xy)));
        op_neg = acc_xy[SQ_W-1];
      end
      ST_SXSY: begin
        opa    = PW'(abs_wide(WIDE_W'(acc_x)));
        opb    = OPW'(abs_wide(WIDE_W'(acc_y)));
        op_neg = acc_x[SUM_W-1] ^ acc_y[SUM_W-1];
      end
      ST_NSXX: begin
        opa    = PW'(count);
        opb    = OPW'(abs_wide(WIDE_W'(acc_xx)));
        op_neg = acc_xx[SQ_W-1];
      end
      ST_SXSX: begin
        opa = PW'(abs_wide(WIDE_W'(acc_x)));
        opb = OPW'(abs_wide(WIDE_W'(acc_x)));
      end
      ST_NSYY: begin
        opa    = PW'(count);
        opb    = OPW'(abs_wide(WIDE_W'(acc_yy)));
        op_neg = acc_yy[SQ_W-1];
      end
      ST_SYSY: begin
        opa = PW'(abs_wide(WIDE_W'(acc_y)));
        opb = OPW'(abs_wide(WIDE_W'(acc_y)));
      end
      ST_SXXSY: begin
        opa    = PW'(abs_wide(WIDE_W'(acc_xx)));
        opb    = OPW'(abs_wide(WIDE_W'(acc_y)));
        op_neg = acc_xx[SQ_W-1] ^ acc_y[SUM_W-1];
      end
      ST_SXSXY: begin
        opa    = PW'(abs_wide(WIDE_W'(acc_x)));
        opb    = OPW'(abs_wide(WIDE_W'(acc_xy)));
        op_neg = acc_x[SUM_W-1] ^ acc_xy[SQ_W-1];
      end
      ST_SLOPE: begin
        mdu_req.op = OP_DIV;
        opa        = PW'(abs_wide(num) << 16);
        opb        = dx[OPW-1:0];
      end
      ST_ICPT: begin
        mdu_req.op = OP_DIV;
        opa        = PW'(abs_wide(inum) << 8);
        opb        = dx[OPW-1:0];
      end
      ST_DXDY: begin
        opa = PW'(dx[OPW-1:0]);
        opb = dy[OPW-1:0];
      end
      ST_SQRT: begin
        mdu_req.op = OP_SQRT;
        opa        = rad;
      end
      ST_CORR: begin
        mdu_req.op = OP_DIV;
        opa        = PW'(abs_wide(num) << 15);
        opb        = sroot;
      end
      ST_DET: begin
        opa = PW'(mg);
        opb = OPW'(mg);
      end
      ST_RD: begin
        rd_en   = 1'b1;
        use_mdu = 1'b0;
      end
      ST_PX: begin
        opa    = PW'(OPW'(abs_wide(WIDE_W'(slope_r))));
        opb    = OPW'(abs_wide(WIDE_W'(rd_x)));
        op_neg = slope_r[OUT_W-1] ^ rd_x[SAMPLE_BITS-1];
      end
      ST_PDIV: begin
        mdu_req.op = OP_DIV;
        opa        = PW'(resid);
        opb        = OPW'(abs_wide(WIDE_W'(rd_y)));
      end
      ST_M100: begin
        opa = PW'(err_sum);
        opb = OPW'(PCT_SCALE);
      end
      ST_MDIV: begin
        mdu_req.op = OP_DIV;
        opa        = rad;
        opb        = OPW'(count);
      end
      default: use_mdu = 1'b0;
    endcase
    mdu_req.start = use_mdu && !issued;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      acc_x     <= '0;
      acc_y     <= '0;
      acc_xy    <= '0;
      acc_xx    <= '0;
      acc_yy    <= '0;
      dropped   <= 1'b0;
      zero_y    <= 1'b0;
      phase     <= '0;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mdu_req.start) issued <= 1'b1;
      else if (mdu_done) issued <= 1'b0;

      if (in_xfer) begin
        phase <= '0;
        if (room) begin
          count  <= count + CNT_W'(1);
          acc_x  <= acc_x + SUM_W'(x_value);
          acc_y  <= acc_y + SUM_W'(y_value);
          zero_y <= zero_y || (y_value == '0);
        end else begin
          dropped <= 1'b1;
        end
      end

      if (state == ST_ACC) begin
        phase <= phase + 2'd1;
        case (phase)
          2'd0:    acc_xy <= acc_xy + SQ_W'(mprod);
          2'd1:    acc_xx <= acc_xx + SQ_W'(mprod);
          default: acc_yy <= acc_yy + SQ_W'(mprod);
        endcase
      end

      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
        count     <= '0;
        acc_x     <= '0;
        acc_y     <= '0;
        acc_xy    <= '0;
        acc_xx    <= '0;
        acc_yy    <= '0;
        dropped   <= 1'b0;
        zero_y    <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // fit datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r    <= x_value;
      y_r    <= y_value;
      last_r <= last_point;
    end

    if (state == ST_CHECK) begin
      slope_r <= '0;
      icpt_r  <= '0;
      corr_r  <= '0;
      det_r   <= '0;
      err_sum <= '0;
      idx     <= '0;
      mape_r  <= (dx_pos && zero_y) ? '1 : '0;
      if (!dx_pos) stat_r <= STAT_X_FLAT;
      else if (!dy_pos) stat_r <= STAT_Y_FLAT;
      else if (zero_y) stat_r <= STAT_ZERO_Y;
      else if (dropped) stat_r <= STAT_OVERFLOW;
      else stat_r <= STAT_OK;
    end

    if (mdu_done) begin
      case (state) inside
        ST_NSXY, ST_NSXX, ST_NSYY, ST_SXXSY: p1 <= prod_s;
        ST_SXSY:  num  <= p1 - prod_s;
        ST_SXSX:  dx   <= p1 - prod_s;
        ST_SYSY:  dy   <= p1 - prod_s;
        ST_SXSXY: inum <= p1 - prod_s;
        ST_SLOPE: slope_r <= sat32(quot, num[WIDE_W-1]);
        ST_ICPT:  icpt_r  <= sat32(quot, inum[WIDE_W-1]);
        ST_DXDY, ST_M100: rad <= mdu_res;
        ST_SQRT:  sroot <= mdu_res[OPW-1:0];
        ST_CORR: begin
          mg     <= mg_new;
          corr_r <= num[WIDE_W-1] ? -CORR_W'(mg_new) : CORR_W'(mg_new);
        end
        ST_DET:   det_r <= mdu_res[2*MG_W-2:14];
        ST_PX:    resid <= res64[RES_W-1] ? OPW'(-res64) : OPW'(res64);
        ST_PDIV: begin
          err_sum <= (err_add > (ERR_W+1)'(ERR_CAP)) ? ERR_CAP : err_add[ERR_W-1:0];
          idx     <= idx + ADDR_W'(1);
        end
        ST_MDIV:  mape_r <= (quot > NUMW'(32'hFFFF_FFFF)) ? '1 : quot[OUT_W-1:0];
        default: ;
      endcase
    end

    // load the result register
    if (state == ST_DONE && out_free) begin
      slope          <= slope_r;
      intercept      <= icpt_r;
      correlation    <= corr_r;
      determination  <= det_r;
      mean_pct_error <= mape_r;
      point_count    <= count;
      status         <= stat_r;
    end
  end

endmodule

[src/lsf_checker.sv]
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks of the line fit core, bound to the top level.
// ----------------------------------------------------------------------------
module lsf_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic signed [lsf_pkg::SAMPLE_BITS-1:0] x_value,
  input logic signed [lsf_pkg::SAMPLE_BITS-1:0] y_value,
  input logic                                   last_point,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [lsf_pkg::OUT_W-1:0]       slope,
  input logic signed [lsf_pkg::OUT_W-1:0]       intercept,
  input logic signed [lsf_pkg::CORR_W-1:0]      correlation,
  input logic [lsf_pkg::CORR_W-1:0]             determination,
  input logic [lsf_pkg::OUT_W-1:0]              mean_pct_error,
  input logic [lsf_pkg::CNT_W-1:0]              point_count,
  input logic [2:0]                             status
);
  import lsf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slope) && $stable(status)
      && $stable(mean_pct_error) && $stable(point_count))
    else $error("result changed while stalled");

  a_x_flat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_X_FLAT |-> slope == '0 && intercept == '0
      && correlation == '0 && determination == '0 && mean_pct_error == '0)
    else $error("flat x result not cleared");

  a_y_flat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_Y_FLAT |-> correlation == '0 && determination == '0)
    else $error("flat y result has correlation");

  a_zero_y: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_ZERO_Y |-> mean_pct_error == '1)
    else $error("zero y sample without saturated error");

  a_det_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_X_FLAT |-> determination <= CORR_W'(65536)
      && point_count <= CNT_W'(MAX_POINTS))
    else $error("determination or count out of range");

endmodule

bind linear_least_squares_fit_core lsf_checker u_lsf_checker (.*);
